@@ src/zz_inv_pkg.sv @@
package zz_inv_pkg;

  // Move direction of the zigzag walk.
  typedef enum logic [1:0] {
    DIR_RIGHT     = 2'd0,
    DIR_DOWN      = 2'd1,
    DIR_UP_RIGHT  = 2'd2,
    DIR_DOWN_LEFT = 2'd3
  } dir_e;

  // Load phase takes coefficients, drain phase reads the block out.
  typedef enum logic {
    ST_LOAD  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned IndexWidth = 6;

endpackage

@@ src/zigzag_inverse_reorder_unit.sv @@
// After the last coefficient of a block is accepted, the unit reads the block out in
//   raster order: state_q turns to drain, then each read lands in rd_data_q.
// Throughput: one beat in per cycle while busy_o is low. There is one block memory,
//   so no coefficient is accepted while a block drains (busy_o high).
// Reset: asynchronous, active low; the walk returns to the top-left corner, no result
//   is pending. The block memory is not cleared. The receiver cannot stall results.
module zigzag_inverse_reorder_unit #(
  parameter int unsigned BLOCK_SIZE = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [zz_inv_pkg::CoefWidth-1:0]  coefficient_i,
  output logic                                result_valid_o,
  output logic signed [zz_inv_pkg::CoefWidth-1:0]  raster_value_o,
  output logic [zz_inv_pkg::IndexWidth-1:0]   raster_index_o,
  output logic                                block_done_o
);
  import zz_inv_pkg::*;

  // Geometry derived from the block size. Row and column need CW bits,
  // a raster or load position needs AW bits.
  localparam int unsigned BlockLen = BLOCK_SIZE * BLOCK_SIZE;
  localparam int unsigned CW       = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int unsigned AW       = $clog2(BlockLen);
  localparam logic [CW-1:0] LastRc  = CW'(BLOCK_SIZE - 1);
  localparam logic [AW-1:0] LastPos = AW'(BlockLen - 1);

  // Walk state and control registers.
  state_e        state_q, state_d;
  dir_e          dir_q, dir_d;
  logic [CW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] loaded_q, loaded_d;
  logic [AW-1:0] rd_pos_q, rd_pos_d;

  // Output pipeline stage that follows the memory read.
  logic          out_valid_q;
  logic [AW-1:0] out_index_q;
  logic          out_done_q;

  // Block memory: written during load, read in raster order during drain.
  logic [CoefWidth-1:0] block_mem [BlockLen];
  logic [CoefWidth-1:0] rd_data_q;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic          mem_re;
  logic [CW-1:0] row_mv, col_mv;
  logic          last_beat;

  assign accept    = start_i && (state_q == ST_LOAD);
  assign busy_o    = (state_q == ST_DRAIN);
  assign last_beat = (loaded_q == LastPos);
  assign mem_we    = accept;
  assign mem_re    = (state_q == ST_DRAIN);
  // Row times block size is a product with a constant, small at these widths.
  assign wr_addr   = AW'(AW'(row_q) * AW'(BLOCK_SIZE)) + AW'(col_q);

  // Step the cursor one place along the zigzag path and pick the next move.
  always_comb begin
    row_mv = row_q;
    col_mv = col_q;
    case (dir_q)
      DIR_RIGHT: begin
        col_mv = col_q + 1'b1;
      end
      DIR_DOWN: begin
        row_mv = row_q + 1'b1;
      end
      DIR_UP_RIGHT: begin
        col_mv = col_q + 1'b1;
        row_mv = row_q - 1'b1;
      end
      default: begin
        col_mv = col_q - 1'b1;
        row_mv = row_q + 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    dir_d    = dir_q;
    row_d    = row_q;
    col_d    = col_q;
    loaded_d = loaded_q;
    rd_pos_d = rd_pos_q;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (last_beat) begin
            // Block complete: restart the walk and read the block out.
            state_d  = ST_DRAIN;
            dir_d    = DIR_RIGHT;
            row_d    = '0;
            col_d    = '0;
            loaded_d = '0;
            rd_pos_d = '0;
          end else begin
            loaded_d = loaded_q + 1'b1;
            row_d    = row_mv;
            col_d    = col_mv;
            case (dir_q)
              DIR_RIGHT: begin
                dir_d = (row_mv == '0) ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
              end
              DIR_DOWN: begin
                dir_d = (col_mv == LastRc) ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
              end
              DIR_UP_RIGHT: begin
                if (col_mv == LastRc) begin
                  dir_d = DIR_DOWN;
                end else if (row_mv == '0) begin
                  dir_d = DIR_RIGHT;
                end else begin
                  dir_d = DIR_UP_RIGHT;
                end
              end
              default: begin
                if (row_mv == LastRc) begin
                  dir_d = DIR_RIGHT;
                end else if (col_mv == '0) begin
                  dir_d = DIR_DOWN;
                end else begin
                  dir_d = DIR_DOWN_LEFT;
                end
              end
            endcase
          end
        end
      end
      ST_DRAIN: begin
        // One raster read per cycle; leave after issuing the last one.
        rd_pos_d = rd_pos_q + 1'b1;
        if (rd_pos_q == LastPos) begin
          state_d  = ST_LOAD;
          rd_pos_d = '0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      dir_q       <= DIR_RIGHT;
      row_q       <= '0;
      col_q       <= '0;
      loaded_q    <= '0;
      rd_pos_q    <= '0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      dir_q       <= dir_d;
      row_q       <= row_d;
      col_q       <= col_d;
      loaded_q    <= loaded_d;
      rd_pos_q    <= rd_pos_d;
      out_valid_q <= mem_re;
      out_done_q  <= mem_re && (rd_pos_q == LastPos);
    end
  end

  // The index travels alongside the read data; it needs no reset.
  always_ff @(posedge clk_i) begin
    out_index_q <= rd_pos_q;
  end

  // Every write of a block lands before the first read of that block, since the
  // drain starts the cycle after the last write, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      block_mem[wr_addr] <= coefficient_i;
    end
    if (mem_re) begin
      rd_data_q <= block_mem[rd_pos_q];
    end
  end

  assign result_valid_o = out_valid_q;
  assign raster_value_o = rd_data_q;
  assign raster_index_o = IndexWidth'(out_index_q);
  assign block_done_o   = out_done_q;

  // The final beat of a block carries the last raster position.
  a_done_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_done_o |-> (result_valid_o && (raster_index_o == IndexWidth'(LastPos))))
    else $error("block done flag not on the last raster position");

  // Accepting the last coefficient of a block starts the readout.
  a_drain_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_beat) |=> (busy_o && (rd_pos_q == '0)))
    else $error("readout did not start after a full block");

  // The walk is back at the top-left corner for the whole readout.
  a_walk_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> ((loaded_q == '0) && (row_q == '0) && (col_q == '0)))
    else $error("walk not restarted during readout");

  // Results are produced in the cycle after a drain read.
  a_result_timing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> result_valid_o)
    else $error("read issued without a result strobe");

endmodule

@@ test/zigzag_inverse_reorder_unit_test.sv @@
`timescale 1ns / 100ps

// Testbench for the inverse zigzag reorder unit.
// Coefficients go in one beat at a time in zigzag scan order. Every 64th
// coefficient closes a block, and the unit then plays the whole block back
// in raster order, one beat per cycle.
module zigzag_inverse_reorder_unit_test;

  import zz_inv_pkg::*;

  localparam int unsigned BlockSize  = 8;
  localparam int unsigned BlockLen   = BlockSize * BlockSize;
  // Eight whole blocks, so that every coefficient sent ends up in a checked
  // raster beat. The first block opens with hand-picked values, the rest are random.
  localparam int unsigned BlockCount = 8;
  localparam int unsigned CoefCount  = BlockCount * BlockLen;
  // This limit sits well above the length of the slowest legal run.
  localparam int unsigned CycleLimit = 200000;

  typedef logic signed [CoefWidth-1:0] coef_t;

  // One raster beat as the unit should present it.
  typedef struct packed {
    coef_t                 value;
    logic [IndexWidth-1:0] index;
    logic                  done;
  } raster_beat_t;

  // Scoreboard. It mirrors the zigzag walk to know where each accepted
  // coefficient lands in the block. When a block is complete, it queues the
  // 64 raster beats that must follow, in order.
  class zigzag_scoreboard;
    coef_t         block_image [BlockLen];
    logic [2:0]    walk_row;
    logic [2:0]    walk_col;
    dir_e          walk_dir;
    int unsigned   coefs_in_block;
    raster_beat_t  expected_rasters [$];
    int unsigned   failures;

    function new();
      walk_row       = '0;
      walk_col       = '0;
      walk_dir       = DIR_RIGHT;
      coefs_in_block = 0;
      failures       = 0;
      foreach (block_image[k]) block_image[k] = '0;
    endfunction

    // Moves the cursor one step along the zigzag path. The turn that follows
    // depends on the move just made and on the edge that the cursor reached.
    function void advance_walk();
      dir_e last_move;
      last_move = walk_dir;
      case (last_move)
        DIR_RIGHT: begin
          walk_col = walk_col + 3'd1;
        end
        DIR_DOWN: begin
          walk_row = walk_row + 3'd1;
        end
        DIR_UP_RIGHT: begin
          walk_col = walk_col + 3'd1;
          walk_row = walk_row - 3'd1;
        end
        default: begin
          walk_col = walk_col - 3'd1;
          walk_row = walk_row + 3'd1;
        end
      endcase
      case (last_move)
        DIR_RIGHT: begin
          walk_dir = (walk_row == 0) ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
        end
        DIR_DOWN: begin
          walk_dir = (walk_col == BlockSize - 1) ? DIR_DOWN_LEFT : DIR_UP_RIGHT;
        end
        DIR_UP_RIGHT: begin
          if (walk_col == BlockSize - 1) walk_dir = DIR_DOWN;
          else if (walk_row == 0) walk_dir = DIR_RIGHT;
          else walk_dir = DIR_UP_RIGHT;
        end
        default: begin
          if (walk_row == BlockSize - 1) walk_dir = DIR_RIGHT;
          else if (walk_col == 0) walk_dir = DIR_DOWN;
          else walk_dir = DIR_DOWN_LEFT;
        end
      endcase
    endfunction

    // Called for each coefficient that the unit accepts.
    function void note_coefficient(coef_t coef);
      int unsigned  slot;
      raster_beat_t beat;
      slot = (walk_row * BlockSize + walk_col) % 64;
      block_image[slot] = coef;
      if (coefs_in_block + 1 < BlockLen) begin
        coefs_in_block++;
        advance_walk();
      end else begin
        for (int unsigned k = 0; k < BlockLen; k++) begin
          beat.value = block_image[k];
          beat.index = k[IndexWidth-1:0];
          beat.done  = (k == BlockLen - 1);
          expected_rasters.push_back(beat);
        end
        walk_row       = '0;
        walk_col       = '0;
        walk_dir       = DIR_RIGHT;
        coefs_in_block = 0;
      end
    endfunction

    function void report_mismatch(string field, int unsigned want, int unsigned got);
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    endfunction

    // Called for each raster beat that the unit presents.
    function void check_raster(coef_t value, logic [IndexWidth-1:0] index, logic done);
      raster_beat_t want;
      if (expected_rasters.size() == 0) begin
        $error("raster beat with no expectation: value %0d, index %0d, block_done %0d",
               value, index, done);
        failures++;
        return;
      end
      want = expected_rasters.pop_front();
      if (value !== want.value) begin
        $error("raster_value: expected %0d, got %0d", want.value, value);
        failures++;
      end
      if (index !== want.index) report_mismatch("raster_index", want.index, index);
      if (done !== want.done) report_mismatch("block_done", want.done, done);
    endfunction

    function int unsigned pending();
      return expected_rasters.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  coef_t                 coefficient_i;
  logic                  result_valid_o;
  coef_t                 raster_value_o;
  logic [IndexWidth-1:0] raster_index_o;
  logic                  block_done_o;

  zigzag_scoreboard zz_board;
  int unsigned      cycle_count = 0;

  zigzag_inverse_reorder_unit #(
    .BLOCK_SIZE(BlockSize)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .coefficient_i  (coefficient_i),
    .result_valid_o (result_valid_o),
    .raster_value_o (raster_value_o),
    .raster_index_o (raster_index_o),
    .block_done_o   (block_done_o)
  );

  always #5 clk_i = ~clk_i;

  // The watchdog ends a run that hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver cannot hold results off, so every strobed cycle is one
  // raster beat. The outputs are sampled at the edge that ends the cycle,
  // before the unit's own updates for that edge take effect.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      zz_board.check_raster(raster_value_o, raster_index_o, block_done_o);
    end
  end

  // Presents one coefficient and holds it until the unit takes it. The
  // unit takes it at an edge where start_i is high and busy_o is low. While
  // the unit drains a block, busy_o is high and the coefficient just waits
  // there. This task is entered and left in the time step of a rising edge.
  task automatic send_coefficient(input coef_t coef);
    start_i       <= 1'b1;
    coefficient_i <= coef;
    do @(posedge clk_i); while (busy_o);
    zz_board.note_coefficient(coef);
  endtask

  // The sender pauses for a random number of cycles. Each extra cycle comes
  // with the given chance in percent. While it pauses, the data port carries
  // junk, which the unit must ignore.
  task automatic pause_sender(input int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i       <= 1'b0;
      coefficient_i <= coef_t'($urandom);
      @(posedge clk_i);
    end
  endtask

  // Random values lean toward the extremes and toward small magnitudes, so
  // that sign handling is exercised as well as full 16-bit patterns.
  function automatic coef_t pick_coefficient();
    case ($urandom_range(9, 0))
      0:       return coef_t'(16'h8000);
      1:       return coef_t'(16'h7FFF);
      2:       return ($urandom_range(1, 0) != 0) ? coef_t'(0) : coef_t'(-1);
      3:       return coef_t'(int'($urandom_range(31, 0)) - 16);
      default: return coef_t'($urandom);
    endcase
  endfunction

  initial begin
    coef_t       opening_coefs [$];
    int unsigned idle_pct;

    // Hand-picked values that start the first block: the two extremes, zero
    // and its neighbors, and patterns that drive every bit both ways.
    opening_coefs = '{
      coef_t'(16'h8000), coef_t'(16'h7FFF), coef_t'(0), coef_t'(-1), coef_t'(1),
      coef_t'(16'h5555), coef_t'(16'hAAAA), coef_t'(16'h00FF), coef_t'(16'hFF00),
      coef_t'(16'h0F0F), coef_t'(16'hF0F0), coef_t'(16'h8001), coef_t'(16'h7FFE),
      coef_t'(-2), coef_t'(2), coef_t'(16'h3333), coef_t'(16'hCCCC),
      coef_t'(16'h0001), coef_t'(16'h4000), coef_t'(16'hC000), coef_t'(-100),
      coef_t'(100), coef_t'(16'h1234), coef_t'(16'hEDCB), coef_t'(16'h8080)
    };

    zz_board      = new();
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    coefficient_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The stream is one run of whole blocks. The hand-picked values open the
    // first block, and random values fill the rest. The sender first idles
    // often, then about half the time, and then runs flat out. The pauses
    // fall at random points of the load and drain phases.
    for (int unsigned n = 0; n < CoefCount; n++) begin
      if (n < CoefCount / 3) idle_pct = 23;
      else if (n < 2 * CoefCount / 3) idle_pct = 50;
      else idle_pct = 0;
      if (n < opening_coefs.size()) send_coefficient(opening_coefs[n]);
      else send_coefficient(pick_coefficient());
      pause_sender(idle_pct);
    end
    start_i <= 1'b0;

    // Wait for the last block to drain. Then keep watching the outputs for stray beats.
    while (zz_board.pending() != 0) @(posedge clk_i);
    repeat (BlockLen + 4) @(posedge clk_i);

    if (zz_board.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/zz_inv_pkg.sv
src/zigzag_inverse_reorder_unit.sv
test/zigzag_inverse_reorder_unit_test.sv
